FILE: rtl/core/evsp_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the event slot pool core.
// Depends on nothing; imported by event_slot_pool_core.
package evsp_pkg;

  localparam int DEFAULT_SLOT_COUNT = 8;
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 3;
  localparam int RECORD_W = 64;
  localparam int STATUS_W = 2;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_READY = 2'd1,
    MARK_BUSY  = 2'd2
  } mark_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_TAKE = 2'd1,
    CMD_FREE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

endpackage

FILE: rtl/core/event_slot_pool_core.sv
`timescale 1ns / 1ps
// Event slot pool: first-fit pool of slots with empty/ready/busy marks.
// Depends on evsp_pkg for mark, command and status codes.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+-----------------------------
//  command  | in_cmd, in_slot_index, in_event_record       | start high, busy low
//  result   | out_status, out_result_slot, out_result_record | out_valid, one cycle each
//
// One command word is taken every cycle; busy stays low.
// Each result passes through the input register, then through the priority
// search and mark update into the result register (the record store read
// is registered at the same edge).
// rst_n is synchronous, active low, and clears every mark to empty.
// The receiver cannot stall: each result word is shown for one cycle only.
module event_slot_pool_core
  import evsp_pkg::*;
#(
  parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [SLOT_W-1:0]   in_slot_index,
  input  logic [RECORD_W-1:0] in_event_record,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_result_slot,
  output logic [RECORD_W-1:0] out_result_record
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Input register: holds the accepted command word.
  logic                in_v_r;
  logic [CMD_W-1:0]    in_cmd_r;
  logic [SLOT_W-1:0]   in_slot_r;
  logic [RECORD_W-1:0] in_rec_r;

  // Slot marks live in flops; records in a memory with a registered read.
  mark_t               mark_r   [SLOT_COUNT];
  mark_t               mark_nxt [SLOT_COUNT];
  logic [RECORD_W-1:0] rec_mem  [SLOT_COUNT];

  // Result register.
  logic                out_valid_r;
  status_t             status_r, status_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                hit_r, hit_nxt;
  logic [RECORD_W-1:0] rd_data_r;

  // Priority search results.
  logic                empty_found, ready_found;
  logic [IDX_W-1:0]    empty_idx, ready_idx;
  logic                wr_en;
  logic [SLOT_COUNT-1:0] occupied;

  // Never stall the command side.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start && !busy;
    end
    if (start && !busy) begin
      in_cmd_r  <= in_cmd;
      in_slot_r <= in_slot_index;
      in_rec_r  <= in_event_record;
    end
  end

  // Lowest empty and lowest ready slot: scan high to low so the lowest wins.
  always_comb begin
    empty_found = 1'b0;
    empty_idx   = '0;
    ready_found = 1'b0;
    ready_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (mark_r[i] == MARK_EMPTY) begin
        empty_found = 1'b1;
        empty_idx   = IDX_W'(i);
      end
      if (mark_r[i] == MARK_READY) begin
        ready_found = 1'b1;
        ready_idx   = IDX_W'(i);
      end
    end
  end

  // Command decode: mark update and result fields.
  always_comb begin
    mark_nxt   = mark_r;
    status_nxt = ST_DONE;
    slot_nxt   = '0;
    hit_nxt    = 1'b0;
    wr_en      = 1'b0;
    if (in_v_r) begin
      unique case (in_cmd_r)
        CMD_ADD: begin
          if (empty_found) begin
            mark_nxt[empty_idx] = MARK_READY;
            wr_en    = 1'b1;
            slot_nxt = SLOT_W'(empty_idx);
          end else begin
            // Pool full: drop the record, leave the marks alone.
            status_nxt = ST_FULL;
          end
        end
        CMD_TAKE: begin
          if (ready_found) begin
            mark_nxt[ready_idx] = MARK_BUSY;
            slot_nxt = SLOT_W'(ready_idx);
            hit_nxt  = 1'b1;
          end else begin
            status_nxt = ST_NONE;
          end
        end
        CMD_FREE: begin
          // A slot number beyond the pool matches nothing and is ignored.
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (int'(in_slot_r) == i) begin
              mark_nxt[i] = MARK_EMPTY;
            end
          end
          slot_nxt = in_slot_r;
        end
        default: begin
          // Unused command code: report done, change nothing.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        mark_r[i] <= MARK_EMPTY;
      end
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      mark_r      <= mark_nxt;
      out_valid_r <= in_v_r;
      hit_r       <= hit_nxt;
    end
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
  end

  // Record store: write on a successful add, read the lowest ready slot.
  // A ready slot was written by an earlier add, so the read never sees
  // an unwritten entry when it matters.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem[empty_idx] <= in_rec_r;
    end
    rd_data_r <= rec_mem[ready_idx];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_result_slot   = slot_r;
  assign out_result_record = hit_r ? rd_data_r : '0;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      occupied[i] = (mark_r[i] != MARK_EMPTY);
    end
  end

  // Every accepted word yields one result.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(in_v_r))
    else $error("result strobe does not follow the input register");

  // A record is returned only with a completed take.
  a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r |-> (out_valid && out_status == ST_DONE))
    else $error("record returned without a completed take");

  // Occupancy moves by at most one slot per command.
  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(occupied) <= $past($countones(occupied)) + 1) &&
    ($countones(occupied) + 1 >= $past($countones(occupied))))
    else $error("occupancy changed by more than one slot");

  // An add decoded with no empty slot is reported as full.
  a_full_real: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && in_cmd_r == CMD_ADD && !empty_found) |=>
    (out_valid && out_status == ST_FULL))
    else $error("full add not reported");

endmodule
